[design/six_button_pad_port_macros.svh]
// ---------------------------------------------------------------------------
// six_button_pad_port_macros: assertion helpers for the pad port core RTL
// ---------------------------------------------------------------------------
`ifndef SIX_BUTTON_PAD_PORT_MACROS_SVH
`define SIX_BUTTON_PAD_PORT_MACROS_SVH

// Checked on every rising edge once reset is released.
`define SBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/sbp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbp_pkg: shared types and constants for the six-button pad port
// ---------------------------------------------------------------------------
package sbp_pkg;

    localparam int unsigned BTN_W     = 12;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TMO_W     = 11;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned S_DATA_W  = 24;
    localparam int unsigned S_USER_W  = 2;

    localparam logic [PHASE_W-1:0] PHASES          = 3'd5;
    localparam logic [TMO_W-1:0]   TIMEOUT_DEFAULT = 11'd1600;

    // Item kind, carried on s_tuser
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } func_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [BYTE_W-1:0] write_data;
        logic [BTN_W-1:0]  buttons;
    } item_t;

    // Result from the core toward the output register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } rd_t;

endpackage

[design/sbp_in_stage.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbp_in_stage: input beat register
// ---------------------------------------------------------------------------
module sbp_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  sbp_pkg::item_t s_item,
    input  logic           take,
    output logic           in_vld,
    output sbp_pkg::item_t in_item
);

    logic           vld_reg, vld_next;
    sbp_pkg::item_t item_reg;

    assign s_tready = !vld_reg || take;
    assign vld_next = s_tready ? s_tvalid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

    assign in_vld  = vld_reg;
    assign in_item = item_reg;

endmodule

[design/sbp_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbp_core: pad state and port read mux
// ---------------------------------------------------------------------------
`include "six_button_pad_port_macros.svh"

module sbp_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sbp_pkg::TMO_W-1:0]       cfg_wdata,
    input  logic                            in_vld,
    input  sbp_pkg::item_t                  in_item,
    input  logic                            out_free,
    output logic                            take,
    output sbp_pkg::rd_t                    rd
);

    logic [sbp_pkg::TMO_W-1:0]   reload_reg;
    logic [sbp_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [sbp_pkg::TMO_W-1:0]   timeout_reg, timeout_next;
    logic                        sel_reg, sel_next;
    logic                        latch_reg, latch_next;
    logic [3:0]                  dir_reg, dir_next;
    logic                        vhold_reg, vhold_next;
    logic                        hhold_reg, hhold_next;

    logic [sbp_pkg::BTN_W-1:0]   btn;
    logic                        wr_sel;
    logic [sbp_pkg::PHASE_W-1:0] ph;
    logic [sbp_pkg::PHASE_W-1:0] ph_inc;
    logic [2:0]                  vpair, hpair;
    logic [5:0]                  d;

    // Pair update: returns {hold, latch[1:0]}
    function automatic logic [2:0] pair_upd(input logic [1:0] pressed,
                                            input logic [1:0] cur,
                                            input logic       hold);
        logic [2:0] r;
        if (pressed != 2'b11) begin
            r = {1'b0, pressed};
        end else if (!hold) begin
            r = {1'b1, cur[0], cur[1]};
        end else begin
            r = {1'b1, cur};
        end
        return r;
    endfunction

    assign btn    = in_item.buttons;
    assign wr_sel = in_item.write_data[6];
    assign take   = in_vld && ((in_item.func != sbp_pkg::FUNC_READ) || out_free);

    // Out-of-range phase reads as 0 and wraps to 0
    assign ph     = (phase_reg >= sbp_pkg::PHASES) ? '0 : phase_reg;
    assign ph_inc = (phase_reg >= sbp_pkg::PHASES - 3'd1) ? '0 : phase_reg + 3'd1;

    assign vpair = pair_upd(btn[1:0], dir_reg[1:0], vhold_reg);
    assign hpair = pair_upd(btn[3:2], dir_reg[3:2], hhold_reg);

    // Six data bits before inversion, using the updated direction latches
    always_comb begin
        if (!sel_reg) begin
            if (ph == 3'd2) begin
                d[3:0] = 4'hF;
            end else if (ph == 3'd3) begin
                d[3:0] = 4'h0;
            end else begin
                d[3:0] = {2'b11, vpair[1:0]};
            end
            d[4] = btn[4];
            d[5] = btn[11];
        end else begin
            if (ph == 3'd3) begin
                d = {2'b00, btn[10], btn[7], btn[8], btn[9]};
            end else begin
                d = {btn[6], btn[5], hpair[1:0], vpair[1:0]};
            end
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        timeout_next = timeout_reg;
        sel_next     = sel_reg;
        latch_next   = latch_reg;
        dir_next     = dir_reg;
        vhold_next   = vhold_reg;
        hhold_next   = hhold_reg;
        rd.valid     = 1'b0;
        rd.data      = {latch_reg, sel_reg, ~d};
        if (take) begin
            unique case (in_item.func)
                sbp_pkg::FUNC_TICK: begin
                    if (timeout_reg != '0) begin
                        timeout_next = timeout_reg - 11'd1;
                    end else begin
                        phase_next = '0;
                    end
                end
                sbp_pkg::FUNC_READ: begin
                    rd.valid   = 1'b1;
                    dir_next   = {hpair[1:0], vpair[1:0]};
                    vhold_next = vpair[2];
                    hhold_next = hpair[2];
                end
                sbp_pkg::FUNC_WRITE: begin
                    if (!sel_reg && wr_sel) begin
                        phase_next = ph_inc;
                    end
                    sel_next     = wr_sel;
                    latch_next   = in_item.write_data[7];
                    timeout_next = reload_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg  <= sbp_pkg::TIMEOUT_DEFAULT;
            phase_reg   <= '0;
            timeout_reg <= '0;
            sel_reg     <= 1'b0;
            latch_reg   <= 1'b0;
            dir_reg     <= '0;
            vhold_reg   <= 1'b0;
            hhold_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                reload_reg <= cfg_wdata;
            end
            phase_reg   <= phase_next;
            timeout_reg <= timeout_next;
            sel_reg     <= sel_next;
            latch_reg   <= latch_next;
            dir_reg     <= dir_next;
            vhold_reg   <= vhold_next;
            hhold_reg   <= hhold_next;
        end
    end

    `SBP_ASSERT(a_phase_range, phase_reg < sbp_pkg::PHASES, "phase counter out of range")
    `SBP_ASSERT(a_write_reload, take && in_item.func == sbp_pkg::FUNC_WRITE |=> timeout_reg == $past(reload_reg), "timeout not reloaded on write")
    `SBP_ASSERT(a_tick_clear, take && in_item.func == sbp_pkg::FUNC_TICK && timeout_reg == '0 |=> phase_reg == '0, "phase not cleared on expired tick")

endmodule

[design/sbp_out_stage.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbp_out_stage: result beat register
// ---------------------------------------------------------------------------
module sbp_out_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sbp_pkg::rd_t               rd,
    output logic                       out_free,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sbp_pkg::BYTE_W-1:0] m_tdata
);

    logic                       vld_reg, vld_next;
    logic [sbp_pkg::BYTE_W-1:0] data_reg;

    assign out_free = !vld_reg || m_tready;
    assign vld_next = out_free ? rd.valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.valid) begin
            data_reg <= rd.data;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;

endmodule

[design/six_button_pad_port.sv]
`timescale 1ns / 1ps
// A read beat passes through the input register and then the result register.
// Throughput: one beat per cycle, any kind, unless a read waits on a full
//   result register; set by the single-pass update between the two registers.
// Reset: synchronous, active-low aresetn; clears pad state, empties both
//   registers and loads the timeout reload with 1600.
// ---------------------------------------------------------------------------
// six_button_pad_port: six-button game pad behind a byte-wide port
// ---------------------------------------------------------------------------
// Input beats are ticks, port writes or port reads (s_tuser). Ticks run the
// select timeout down; an expired timeout resets the phase counter. Writes
// set select/latch and reload the timeout, and a select rising edge steps the
// phase 0..4. Reads return latch, select and six active-low pad bits chosen
// by select and phase; only reads produce a result beat.
//
// Pipeline:
//   sbp_in_stage  - input beat register, ready when empty or draining
//   sbp_core      - pad state, read mux, timeout/config register
//   sbp_out_stage - result register; a read stalls only if it is full and
//                   not being taken
// ---------------------------------------------------------------------------
module six_button_pad_port (
    input  logic        aclk,
    input  logic        aresetn,
    // Timeout reload register, write only
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    // Input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] write_data, [19:8] buttons, [23:20] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    // Result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] read_data
);

    sbp_pkg::item_t s_item;
    sbp_pkg::item_t in_item;
    sbp_pkg::rd_t   rd;
    logic           in_vld;
    logic           take;
    logic           out_free;

    assign s_item.func       = s_tuser;
    assign s_item.write_data = s_tdata[7:0];
    assign s_item.buttons    = s_tdata[19:8];

    sbp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .take     (take),
        .in_vld   (in_vld),
        .in_item  (in_item)
    );

    sbp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_vld    (in_vld),
        .in_item   (in_item),
        .out_free  (out_free),
        .take      (take),
        .rd        (rd)
    );

    sbp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd       (rd),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the six-button pad port
// ---------------------------------------------------------------------------
// Streams tick, port-write, port-read and unused-kind beats into the pad port
// and checks every read result against a typed value or an in-bench model
// of the pad: phase counter, select timeout, latch/select bits and the
// opposite-direction swap and hold. A short directed table runs first, then
// random pad polling with tick runs and noise, under several timeout reload
// settings. Both sides of the stream idle at random.
// ---------------------------------------------------------------------------
module tb_top;

    // Kind code with no function; the block must drop it without a result
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Phases with their own read mux behavior
    localparam logic [2:0] PH_DETECT = 3'd2;
    localparam logic [2:0] PH_EXTRA  = 3'd3;

    localparam int PLAN_ROWS   = 24;
    localparam int PHASE_ITEMS = 188;   // at least this many random beats per reload setting
    localparam int DRAIN_WAIT  = 4;     // result register loads after the input register
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] write_data, [19:8] buttons, [23:20] zero
    logic [1:0]  s_tuser;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] read_data

    six_button_pad_port i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // -----------------------------------------------------------------------
    // Pad model state, mirrors the block after reset
    // -----------------------------------------------------------------------
    logic [2:0]  pad_phase  = '0;
    logic [10:0] tmo_left   = '0;
    logic        pad_sel    = 1'b0;
    logic        pad_latch  = 1'b0;
    logic [3:0]  dir_latch  = '0;   // up, down, left, right from bit 0
    logic        hold_v     = 1'b0;
    logic        hold_h     = 1'b0;
    logic [10:0] tmo_reload = sbp_pkg::TIMEOUT_DEFAULT;

    logic [7:0] read_data_q [$];    // read results still owed by the block

    int n_errors = 0;
    int n_checked = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_ticks = 0;
    int n_unused = 0;
    int n_clears = 0;
    int n_swaps = 0;
    int cycles = 0;

    bit src_quiet = 1'b0;
    bit snk_quiet = 1'b0;

    // One direction pair: returns {hold, latched pair}. Both pressed swaps the
    // latched pair once, then holds it until the pair is released.
    function automatic logic [2:0] pair_next(input logic [1:0] pressed,
                                             input logic [1:0] cur,
                                             input logic hold);
        if (pressed != 2'b11)
            return {1'b0, pressed};
        else if (!hold)
            return {1'b1, cur[0], cur[1]};
        return {1'b1, cur};
    endfunction

    // Port read: updates the direction latches, then muxes by select/phase
    function automatic logic [7:0] pad_read_predict(input logic [11:0] btn);
        logic [2:0] ph;
        logic [2:0] nv;
        logic [2:0] nh;
        logic [5:0] d;
        ph = (pad_phase >= sbp_pkg::PHASES) ? 3'd0 : pad_phase;
        nv = pair_next(btn[1:0], dir_latch[1:0], hold_v);
        nh = pair_next(btn[3:2], dir_latch[3:2], hold_h);
        if (nv[2] && !hold_v) n_swaps++;
        if (nh[2] && !hold_h) n_swaps++;
        hold_v = nv[2];
        hold_h = nh[2];
        dir_latch = {nh[1:0], nv[1:0]};
        if (!pad_sel) begin
            case (ph)
                PH_DETECT: d[3:0] = 4'hF;
                PH_EXTRA:  d[3:0] = 4'h0;
                default:   d[3:0] = {2'b11, dir_latch[1:0]};
            endcase
            d[5:4] = {btn[11], btn[4]};         // start, a
        end else if (ph == PH_EXTRA) begin
            d = {2'b00, btn[10], btn[7], btn[8], btn[9]};   // mode x y z
        end else begin
            d = {btn[6], btn[5], dir_latch};    // c, b, directions
        end
        return {pad_latch, pad_sel, ~d};
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        n_errors++;
        $display("%0t: %s: got 0x%02h, want 0x%02h", $realtime, what, got, want);
    endtask

    // Draws a per-beat wait; quiet stretches give back-to-back beats
    task automatic pick_wait(inout bit quiet, output int n);
        if ($urandom_range(0, 99) < 4) quiet = ~quiet;
        n = quiet ? 0 : $urandom_range(0, 10);
    endtask

    // Drives one input beat, waits for the handshake and updates the model.
    // chk selects the typed expectation over the model's for reads.
    task automatic send_beat(input logic [1:0] fn, input logic [7:0] wd,
                             input logic [11:0] btn, input bit chk,
                             input logic [7:0] want);
        int gap;
        logic [7:0] rd;
        pick_wait(src_quiet, gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {4'h0, btn, wd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (fn)
            sbp_pkg::FUNC_TICK: begin
                n_ticks++;
                if (tmo_left != 0) begin
                    tmo_left = tmo_left - 1'b1;
                end else begin
                    if (pad_phase != 0) n_clears++;
                    pad_phase = '0;
                end
            end
            sbp_pkg::FUNC_READ: begin
                n_reads++;
                rd = pad_read_predict(btn);
                read_data_q.push_back(chk ? want : rd);
            end
            sbp_pkg::FUNC_WRITE: begin
                n_writes++;
                // select rising edge steps the phase, wrapping after phase 4
                if (!pad_sel && wd[6])
                    pad_phase = ({1'b0, pad_phase} + 4'd1 >= {1'b0, sbp_pkg::PHASES}) ?
                                3'd0 : pad_phase + 3'd1;
                pad_sel   = wd[6];
                pad_latch = wd[7];
                tmo_left  = tmo_reload;
            end
            default: n_unused++;
        endcase
    endtask

    // Reload writes happen only with the pipe empty: all results in, then an
    // idle wait for trailing ticks and writes to pass through.
    task automatic set_reload(input logic [10:0] value);
        s_tvalid <= 1'b0;
        while (read_data_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tmo_reload = value;
    endtask

    // Random traffic, mostly well-formed polls: toggle select, then read
    task automatic random_burst(inout int sent);
        int r;
        int len;
        logic [7:0] wd;
        logic [11:0] btn;
        r = $urandom_range(0, 99);
        wd = 8'($urandom);
        btn = 12'($urandom);
        if (r < 55) begin
            wd[6] = ~pad_sel;
            send_beat(sbp_pkg::FUNC_WRITE, wd, 12'($urandom), 1'b0, 8'h00);
            send_beat(sbp_pkg::FUNC_READ, 8'($urandom), btn, 1'b0, 8'h00);
            sent += 2;
        end else if (r < 70) begin
            // tick run, long enough to expire the short reload settings
            len = $urandom_range(1, 24);
            repeat (len) send_beat(sbp_pkg::FUNC_TICK, 8'($urandom), 12'($urandom),
                                   1'b0, 8'h00);
            sent += len;
        end else if (r < 85) begin
            send_beat(sbp_pkg::FUNC_READ, wd, btn, 1'b0, 8'h00);
            sent++;
        end else if (r < 93) begin
            send_beat(sbp_pkg::FUNC_WRITE, wd, btn, 1'b0, 8'h00);
            sent++;
        end else begin
            send_beat(FUNC_UNUSED, wd, btn, 1'b0, 8'h00);
            sent++;
        end
    endtask

    // -----------------------------------------------------------------------
    // Result side: random stalls, every beat checked against the oldest
    // expectation
    // -----------------------------------------------------------------------
    initial begin
        int stall;
        logic [7:0] want;
        m_tready = 1'b0;
        forever begin
            pick_wait(snk_quiet, stall);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (read_data_q.size() == 0) begin
                report_mismatch("result beat with no read pending", m_tdata, 8'h00);
            end else begin
                want = read_data_q.pop_front();
                n_checked++;
                if (m_tdata !== want)
                    report_mismatch("read_data", m_tdata, want);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads pending",
                     cycles, read_data_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Directed table row: kind, write byte, buttons, typed check, typed value
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  wd;
        logic [11:0] btn;
        logic        chk;
        logic [7:0]  want;
    } plan_row_t;

    plan_row_t plan [0:PLAN_ROWS-1];

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        int sent;
        logic [10:0] rl;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;

        // Out of reset: select low, phase 0, latches clear
        plan[0]  = {sbp_pkg::FUNC_READ,  8'h00, 12'h000, 1'b1, 8'h33};
        // all pressed: swap of clear latches, then hold
        plan[1]  = {sbp_pkg::FUNC_READ,  8'h00, 12'hFFF, 1'b1, 8'h03};
        plan[2]  = {sbp_pkg::FUNC_READ,  8'h00, 12'hFFF, 1'b1, 8'h03};
        plan[3]  = {sbp_pkg::FUNC_READ,  8'h00, 12'h001, 1'b0, 8'h00};
        plan[4]  = {sbp_pkg::FUNC_WRITE, 8'h40, 12'h000, 1'b0, 8'h00};   // phase 1
        // up latched, both pressed again: swaps to down
        plan[5]  = {sbp_pkg::FUNC_READ,  8'h00, 12'hFFF, 1'b0, 8'h00};
        plan[6]  = {sbp_pkg::FUNC_WRITE, 8'h80, 12'h000, 1'b0, 8'h00};
        plan[7]  = {sbp_pkg::FUNC_WRITE, 8'hC0, 12'h000, 1'b0, 8'h00};   // phase 2
        plan[8]  = {sbp_pkg::FUNC_READ,  8'h00, 12'h000, 1'b1, 8'hFF};
        plan[9]  = {sbp_pkg::FUNC_WRITE, 8'h00, 12'h000, 1'b0, 8'h00};
        // detection code: select low in phase 2
        plan[10] = {sbp_pkg::FUNC_READ,  8'h00, 12'h811, 1'b1, 8'h00};
        plan[11] = {sbp_pkg::FUNC_WRITE, 8'h40, 12'h000, 1'b0, 8'h00};   // phase 3
        plan[12] = {sbp_pkg::FUNC_READ,  8'hFF, 12'hFFF, 1'b1, 8'h70};   // x y z mode
        plan[13] = {sbp_pkg::FUNC_WRITE, 8'hBF, 12'h000, 1'b0, 8'h00};
        plan[14] = {sbp_pkg::FUNC_READ,  8'h00, 12'hFFF, 1'b1, 8'h8F};   // zeros, a, start
        plan[15] = {sbp_pkg::FUNC_WRITE, 8'h40, 12'h000, 1'b0, 8'h00};   // phase 4
        plan[16] = {sbp_pkg::FUNC_READ,  8'h00, 12'h0F0, 1'b0, 8'h00};
        plan[17] = {sbp_pkg::FUNC_WRITE, 8'h00, 12'h000, 1'b0, 8'h00};
        plan[18] = {sbp_pkg::FUNC_WRITE, 8'h40, 12'h000, 1'b0, 8'h00};   // wraps to 0
        plan[19] = {sbp_pkg::FUNC_READ,  8'h00, 12'hAAA, 1'b0, 8'h00};
        plan[20] = {FUNC_UNUSED,         8'hFF, 12'hFFF, 1'b0, 8'h00};   // dropped
        plan[21] = {sbp_pkg::FUNC_TICK,  8'hFF, 12'hFFF, 1'b0, 8'h00};
        plan[22] = {sbp_pkg::FUNC_WRITE, 8'hFF, 12'h000, 1'b0, 8'h00};   // no edge
        plan[23] = {sbp_pkg::FUNC_READ,  8'h00, 12'h555, 1'b0, 8'h00};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_ROWS; i++)
            send_beat(plan[i].func, plan[i].wd, plan[i].btn, plan[i].chk, plan[i].want);

        // Random part under six reload settings; the first keeps the reset value
        for (int p = 0; p < 6; p++) begin
            case (p)
                1:       rl = 11'd0;
                2:       rl = 11'h7FF;
                3:       rl = 11'd1;
                4:       rl = 11'd7;
                default: rl = 11'($urandom_range(2, 20));
            endcase
            if (p > 0) set_reload(rl);
            sent = 0;
            while (sent < PHASE_ITEMS) random_burst(sent);
        end

        s_tvalid <= 1'b0;
        while (read_data_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d reads (%0d results checked), %0d writes, %0d ticks, %0d unused",
                 n_reads, n_checked, n_writes, n_ticks, n_unused);
        $display("timeout phase clears %0d, direction swaps %0d, six reload settings",
                 n_clears, n_swaps);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
